@@ sv/mvta_pkg.sv @@
`timescale 1ns / 1ps
package mvta_pkg;

  localparam int MaxWidthDefault = 128;
  localparam int MaxHeightDefault = 128;
  localparam int CoordW = 16;
  localparam int DimW = 8;
  localparam int CountW = 16;
  localparam int HalfW = 6;
  localparam int OffW = 8;
  localparam int PosW = 18;
  localparam logic [DimW-1:0] FrameDimReset = 8'd128;
  localparam logic [CountW-1:0] CountMax = 16'hFFFF;

  typedef enum logic [1:0] {
    CMD_START  = 2'd0,
    CMD_VECTOR = 2'd1,
    CMD_END    = 2'd2,
    CMD_READ   = 2'd3
  } cmd_t;

  typedef enum logic {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_COPY,
    ST_COPY_LAST,
    ST_PIX_A,
    ST_PIX_B,
    ST_PIX_C,
    ST_READ
  } state_t;

  typedef struct packed {
    cmd_t                     cmd;
    logic                     intra;
    logic                     still;
    logic signed [CoordW-1:0] src_x;
    logic signed [CoordW-1:0] src_y;
    logic signed [CoordW-1:0] dst_x;
    logic signed [CoordW-1:0] dst_y;
    logic [CoordW-1:0]        vx;
    logic [CoordW-1:0]        vy;
    logic [HalfW-1:0]         hw;
    logic [HalfW-1:0]         hh;
    logic [6:0]               read_x;
    logic [6:0]               read_y;
  } item_t;

  typedef struct packed {
    logic pop;
    logic hold;
  } back_ctrl_t;

endpackage

@@ sv/mvta_front.sv @@
`timescale 1ns / 1ps
module mvta_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [1:0]                          cmd,
  input  logic                                intra,
  input  logic signed [mvta_pkg::CoordW-1:0]  src_x,
  input  logic signed [mvta_pkg::CoordW-1:0]  src_y,
  input  logic signed [mvta_pkg::CoordW-1:0]  dst_x,
  input  logic signed [mvta_pkg::CoordW-1:0]  dst_y,
  input  logic [6:0]                          blk_w,
  input  logic [6:0]                          blk_h,
  input  logic [6:0]                          read_x,
  input  logic [6:0]                          read_y,
  input  mvta_pkg::back_ctrl_t                ctrl,
  output mvta_pkg::item_t                     head,
  output logic                                head_valid
);
  import mvta_pkg::*;

  item_t      slot [2];
  item_t      item_in;
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;

  always_comb begin
    item_in.cmd    = cmd_t'(cmd);
    item_in.intra  = intra;
    item_in.src_x  = src_x;
    item_in.src_y  = src_y;
    item_in.dst_x  = dst_x;
    item_in.dst_y  = dst_y;
    item_in.vx     = dst_x - src_x;
    item_in.vy     = dst_y - src_y;
    item_in.still  = (item_in.vx == '0) && (item_in.vy == '0);
    item_in.hw     = blk_w[6:1];
    item_in.hh     = blk_h[6:1];
    item_in.read_x = read_x;
    item_in.read_y = read_y;
  end

  assign busy       = (count == 2'd2) || ctrl.hold;
  assign push       = start && !busy;
  assign head       = slot[rd_ptr];
  assign head_valid = (count != 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (ctrl.pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, ctrl.pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= item_in;
    end
  end

endmodule

@@ sv/mvta_back.sv @@
`timescale 1ns / 1ps
module mvta_back #(
  parameter int MAX_WIDTH  = mvta_pkg::MaxWidthDefault,
  parameter int MAX_HEIGHT = mvta_pkg::MaxHeightDefault
) (
  input  logic                               clk,
  input  logic                               rst,
  input  mvta_pkg::item_t                    head,
  input  logic                               head_valid,
  output mvta_pkg::back_ctrl_t               ctrl,
  input  logic [mvta_pkg::DimW-1:0]          frame_width,
  input  logic [mvta_pkg::DimW-1:0]          frame_height,
  output logic                               result_valid,
  output logic signed [mvta_pkg::CoordW-1:0] sum_dx,
  output logic signed [mvta_pkg::CoordW-1:0] sum_dy,
  output logic [mvta_pkg::CountW-1:0]        mv_count
);
  import mvta_pkg::*;

  localparam int XW = $clog2(MAX_WIDTH);
  localparam int YW = $clog2(MAX_HEIGHT);
  localparam int AW = XW + YW;
  localparam int Depth = 2 ** AW;

  logic [AW-1:0] prev_mem [Depth];
  logic [AW-1:0] curr_mem [Depth];
  logic [2*CoordW-1:0] sum_mem [Depth];

  state_t state;
  state_t state_next;
  logic   boot;
  logic   maps_ready;
  logic [CountW-1:0] vector_count;

  logic signed [PosW-1:0] eff_w;
  logic signed [PosW-1:0] eff_h;

  logic [XW-1:0] swp_x;
  logic [YW-1:0] swp_y;
  logic [AW-1:0] swp_addr;
  logic          swp_last;
  logic          copy_wr;
  logic [AW-1:0] copy_addr;

  logic signed [CoordW-1:0] sx_q;
  logic signed [CoordW-1:0] sy_q;
  logic signed [CoordW-1:0] dx_q;
  logic signed [CoordW-1:0] dy_q;
  logic [CoordW-1:0]        vx_q;
  logic [CoordW-1:0]        vy_q;
  logic [HalfW-1:0]         hw_q;
  logic [HalfW-1:0]         hh_q;
  logic signed [OffW-1:0]   ox;
  logic signed [OffW-1:0]   oy;
  logic signed [OffW-1:0]   ox_last;
  logic signed [OffW-1:0]   oy_last;
  logic                     walk_last;
  logic signed [PosW-1:0]   px;
  logic signed [PosW-1:0]   py;
  logic signed [PosW-1:0]   qx;
  logic signed [PosW-1:0]   qy;
  logic                     in_frame;
  logic [AW-1:0]            di_q;
  logic [AW-1:0]            gi_q;
  logic                     gi_ok_q;
  logic                     gi_ok;
  logic                     read_ok_q;
  logic                     advance;
  logic                     dispatch;

  logic          prev_we;
  logic [AW-1:0] prev_waddr;
  logic [AW-1:0] prev_wdata;
  logic [AW-1:0] prev_raddr;
  logic [AW-1:0] prev_rdata;
  logic          curr_we;
  logic [AW-1:0] curr_waddr;
  logic [AW-1:0] curr_wdata;
  logic [AW-1:0] curr_rdata;
  logic          sum_we;
  logic [AW-1:0] sum_waddr;
  logic [2*CoordW-1:0] sum_wdata;
  logic [AW-1:0] sum_raddr;
  logic [2*CoordW-1:0] sum_rdata;

  assign swp_addr = {swp_y, swp_x};
  assign swp_last = (swp_x == XW'(MAX_WIDTH - 1)) && (swp_y == YW'(MAX_HEIGHT - 1));
  assign dispatch = (state == ST_IDLE) && head_valid;

  assign px = PosW'(sx_q) + PosW'(ox);
  assign py = PosW'(sy_q) + PosW'(oy);
  assign qx = PosW'(dx_q) + PosW'(ox);
  assign qy = PosW'(dy_q) + PosW'(oy);
  assign in_frame = !px[PosW-1] && (px < eff_w) && !py[PosW-1] && (py < eff_h) &&
                    !qx[PosW-1] && (qx < eff_w) && !qy[PosW-1] && (qy < eff_h);
  assign ox_last = $signed({2'b00, hw_q}) - OffW'(1);
  assign oy_last = $signed({2'b00, hh_q}) - OffW'(1);
  assign walk_last = (ox == ox_last) && (oy == oy_last);
  assign advance = ((state == ST_PIX_A) && !in_frame) || (state == ST_PIX_C);
  assign gi_ok = ({1'b0, prev_rdata[XW-1:0]} < (XW+1)'(MAX_WIDTH)) &&
                 ({1'b0, prev_rdata[AW-1:XW]} < (YW+1)'(MAX_HEIGHT));

  always_comb begin
    state_next = state;
    ctrl.hold = boot;
    ctrl.pop = 1'b0;
    case (state)
      ST_SWEEP: begin
        if (swp_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (head_valid) begin
          ctrl.pop = 1'b1;
          case (head.cmd)
            CMD_START: begin
              if (head.intra || !maps_ready) state_next = ST_SWEEP;
            end
            CMD_VECTOR: begin
              if (!head.still && (head.hw != '0) && (head.hh != '0)) state_next = ST_PIX_A;
            end
            CMD_END: state_next = ST_COPY;
            CMD_READ: state_next = ST_READ;
            default: state_next = ST_IDLE;
          endcase
        end
      end
      ST_COPY: begin
        if (swp_last) state_next = ST_COPY_LAST;
      end
      ST_COPY_LAST: state_next = ST_IDLE;
      ST_PIX_A: begin
        if (in_frame) state_next = ST_PIX_B;
        else if (walk_last) state_next = ST_IDLE;
      end
      ST_PIX_B: state_next = ST_PIX_C;
      ST_PIX_C: begin
        state_next = walk_last ? ST_IDLE : ST_PIX_A;
      end
      ST_READ: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_SWEEP;
      boot         <= 1'b1;
      maps_ready   <= 1'b0;
      vector_count <= '0;
      swp_x        <= '0;
      swp_y        <= '0;
      copy_wr      <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state   <= state_next;
      copy_wr <= (state == ST_COPY);
      if ((state == ST_SWEEP) && swp_last) boot <= 1'b0;
      if ((state == ST_SWEEP) || (state == ST_COPY)) begin
        if (swp_x == XW'(MAX_WIDTH - 1)) begin
          swp_x <= '0;
          swp_y <= swp_last ? '0 : swp_y + YW'(1);
        end else begin
          swp_x <= swp_x + XW'(1);
        end
      end
      if (dispatch) begin
        case (head.cmd)
          CMD_START: begin
            vector_count <= '0;
            maps_ready   <= 1'b1;
          end
          CMD_VECTOR: begin
            if (vector_count != CountMax) vector_count <= vector_count + CountW'(1);
          end
          CMD_END: vector_count <= '0;
          default: vector_count <= vector_count;
        endcase
      end
      result_valid <= (dispatch && (head.cmd == CMD_END)) || (state == ST_READ);
    end
  end

  always_ff @(posedge clk) begin
    if (frame_width == '0) eff_w <= PosW'(1);
    else if (int'(frame_width) > MAX_WIDTH) eff_w <= PosW'(MAX_WIDTH);
    else eff_w <= PosW'(frame_width);
    if (frame_height == '0) eff_h <= PosW'(1);
    else if (int'(frame_height) > MAX_HEIGHT) eff_h <= PosW'(MAX_HEIGHT);
    else eff_h <= PosW'(frame_height);
    copy_addr <= swp_addr;
    if (dispatch) begin
      sx_q      <= head.src_x;
      sy_q      <= head.src_y;
      dx_q      <= head.dst_x;
      dy_q      <= head.dst_y;
      vx_q      <= head.vx;
      vy_q      <= head.vy;
      hw_q      <= head.hw;
      hh_q      <= head.hh;
      ox        <= -$signed({2'b00, head.hw});
      oy        <= -$signed({2'b00, head.hh});
      read_ok_q <= (int'(head.read_x) < MAX_WIDTH) && (int'(head.read_y) < MAX_HEIGHT);
    end
    if (state == ST_PIX_A) di_q <= {qy[YW-1:0], qx[XW-1:0]};
    if (state == ST_PIX_B) begin
      gi_q    <= prev_rdata;
      gi_ok_q <= gi_ok;
    end
    if (advance) begin
      if (oy == oy_last) begin
        oy <= -$signed({2'b00, hh_q});
        ox <= ox + OffW'(1);
      end else begin
        oy <= oy + OffW'(1);
      end
    end
    sum_dx   <= ((state == ST_READ) && read_ok_q) ? sum_rdata[CoordW-1:0] : '0;
    sum_dy   <= ((state == ST_READ) && read_ok_q) ? sum_rdata[2*CoordW-1:CoordW] : '0;
    mv_count <= (state == ST_READ) ? '0 : vector_count;
  end

  always_comb begin
    prev_we    = (state == ST_SWEEP) || copy_wr;
    prev_waddr = (state == ST_SWEEP) ? swp_addr : copy_addr;
    prev_wdata = (state == ST_SWEEP) ? swp_addr : curr_rdata;
    prev_raddr = {py[YW-1:0], px[XW-1:0]};
    curr_we    = (state == ST_SWEEP) || (state == ST_PIX_B);
    curr_waddr = (state == ST_SWEEP) ? swp_addr : di_q;
    curr_wdata = (state == ST_SWEEP) ? swp_addr : prev_rdata;
    sum_we     = (state == ST_SWEEP) || ((state == ST_PIX_C) && gi_ok_q);
    sum_waddr  = (state == ST_SWEEP) ? swp_addr : gi_q;
    sum_wdata  = (state == ST_SWEEP) ? '0 :
                 {sum_rdata[2*CoordW-1:CoordW] + vy_q, sum_rdata[CoordW-1:0] + vx_q};
    sum_raddr  = (state == ST_IDLE) ? {YW'(head.read_y), XW'(head.read_x)} : prev_rdata;
  end

  always_ff @(posedge clk) begin
    if (prev_we) prev_mem[prev_waddr] <= prev_wdata;
    prev_rdata <= prev_mem[prev_raddr];
  end

  always_ff @(posedge clk) begin
    if (curr_we) curr_mem[curr_waddr] <= curr_wdata;
    curr_rdata <= curr_mem[swp_addr];
  end

  always_ff @(posedge clk) begin
    if (sum_we) sum_mem[sum_waddr] <= sum_wdata;
    sum_rdata <= sum_mem[sum_raddr];
  end

endmodule

@@ sv/motion_vector_trajectory_accumulator_top.sv @@
`timescale 1ns / 1ps
// Channel   Handshake                Payload
// command   start / busy             cmd intra src_x src_y dst_x dst_y blk_w blk_h read_x read_y
// result    result_valid (strobe)    sum_dx sum_dy mv_count
// config    cfg_valid / cfg_ready    cfg_index cfg_data
//
// Every command is dispatched from the queue while the engine is idle.
// A motion vector then runs PIX_A, PIX_B, PIX_C per in-frame pixel and PIX_A per skipped pixel.
// A frame start that sets up the maps sweeps every map entry;
// frame end copies the current map into the previous map.
// A read strobes from state ST_READ; the frame end strobe is registered from its dispatch.
// After reset the sums are cleared by a sweep of all map entries with busy held high.
// A two-entry queue lets commands be taken while the engine works; busy rises when it fills.
module motion_vector_trajectory_accumulator_top #(
  parameter int MAX_WIDTH  = mvta_pkg::MaxWidthDefault,
  parameter int MAX_HEIGHT = mvta_pkg::MaxHeightDefault
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic [1:0]                         cmd,
  input  logic                               intra,
  input  logic signed [mvta_pkg::CoordW-1:0] src_x,
  input  logic signed [mvta_pkg::CoordW-1:0] src_y,
  input  logic signed [mvta_pkg::CoordW-1:0] dst_x,
  input  logic signed [mvta_pkg::CoordW-1:0] dst_y,
  input  logic [6:0]                         blk_w,
  input  logic [6:0]                         blk_h,
  input  logic [6:0]                         read_x,
  input  logic [6:0]                         read_y,
  output logic                               result_valid,
  output logic signed [mvta_pkg::CoordW-1:0] sum_dx,
  output logic signed [mvta_pkg::CoordW-1:0] sum_dy,
  output logic [mvta_pkg::CountW-1:0]        mv_count,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic                               cfg_index,
  input  logic [mvta_pkg::DimW-1:0]          cfg_data
);
  import mvta_pkg::*;

  logic [DimW-1:0] frame_width;
  logic [DimW-1:0] frame_height;
  item_t           head;
  logic            head_valid;
  back_ctrl_t      ctrl;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FrameDimReset;
      frame_height <= FrameDimReset;
    end else if (cfg_valid && cfg_ready) begin
      case (reg_idx_t'(cfg_index))
        REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        REG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: frame_width <= frame_width;
      endcase
    end
  end

  mvta_front u_front (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .cmd        (cmd),
    .intra      (intra),
    .src_x      (src_x),
    .src_y      (src_y),
    .dst_x      (dst_x),
    .dst_y      (dst_y),
    .blk_w      (blk_w),
    .blk_h      (blk_h),
    .read_x     (read_x),
    .read_y     (read_y),
    .ctrl       (ctrl),
    .head       (head),
    .head_valid (head_valid)
  );

  mvta_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .head_valid   (head_valid),
    .ctrl         (ctrl),
    .frame_width  (frame_width),
    .frame_height (frame_height),
    .result_valid (result_valid),
    .sum_dx       (sum_dx),
    .sum_dy       (sum_dy),
    .mv_count     (mv_count)
  );

`ifndef SYNTHESIS
  a_busy_after_reset: assert property (@(posedge clk) rst |=> busy)
    else $error("busy low straight after reset");
  a_pop_needs_item: assert property (@(posedge clk) disable iff (rst) ctrl.pop |-> head_valid)
    else $error("engine took an item from an empty queue");
  a_result_shape: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (mv_count == '0) || ((sum_dx == '0) && (sum_dy == '0)))
    else $error("result carries both sums and a count");
`endif

endmodule
